FILE: sv/tcl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcl_pkg;

   localparam int BYTE_W  = 8;
   localparam int GLYPH_W = 16;
   localparam int POS_W   = 5;
   localparam int CNT_W   = 6;
   localparam int CFG_W   = 6;
   localparam int IDX_W   = 2;

   localparam int MAX_ROWS    = 32;
   localparam int MAX_COLUMNS = 32;

   localparam logic [CFG_W-1:0]  RESET_ROW_COUNT    = 6'd4;
   localparam logic [CFG_W-1:0]  RESET_COLUMN_COUNT = 6'd8;
   localparam logic [CNT_W-1:0]  COUNT_SAT          = 6'd63;
   localparam logic [BYTE_W-1:0] NEWLINE_BYTE       = 8'h0A;

   localparam logic [IDX_W-1:0] REG_ROW_COUNT      = 2'd0;
   localparam logic [IDX_W-1:0] REG_COLUMN_COUNT   = 2'd1;
   localparam logic [IDX_W-1:0] REG_IGNORE_NEWLINE = 2'd2;

   typedef struct packed {
      logic load;
      logic apply;
      logic blank_step;
      logic nl_mode;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic nl_fill;
      logic glyph;
      logic fill_after_act;
      logic row_end;
      logic fill_after_nl;
      logic eot;
   } status_type;

endpackage

`default_nettype wire

FILE: sv/tcl_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcl_req_if;
   logic                        valid;
   logic                        ready;
   logic [tcl_pkg::BYTE_W-1:0]  text_byte;
   logic                        end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink (input valid, text_byte, end_of_text, output ready);
endinterface

`default_nettype wire

FILE: sv/tcl_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tcl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [tcl_pkg::POS_W-1:0]    cell_row;
   logic [tcl_pkg::POS_W-1:0]    cell_column;
   logic [tcl_pkg::GLYPH_W-1:0]  glyph_code;
   logic                         is_blank;
   logic                         last_of_run;

   modport source (output valid, cell_row, cell_column, glyph_code, is_blank, last_of_run,
                   input ready);
   modport sink (input valid, cell_row, cell_column, glyph_code, is_blank, last_of_run,
                 output ready);
endinterface

`default_nettype wire

FILE: sv/text_cell_layout.sv
// a byte is taken in the idle state and decoded in the next; a glyph cell is written to the
//    output register when decode applies it, which waits while the output register is held
// each byte is taken only in idle and decoded before the next byte is accepted; blank runs
//    emit one blank cell per step (up to 2 x clamped column count cells for newline plus
//    end of text), and the run stalls while the output register is held
// reset: synchronous, active high; clears layout state, the control state and the output
//    valid flag and restores row count 4, column count 8, newlines honored
`timescale 1ns / 1ps
`default_nettype none

module text_cell_layout (
   input  wire logic                      clock,
   input  wire logic                      reset,
   tcl_req_if.sink                        req,
   tcl_rsp_if.source                      rsp,
   input  wire logic                      csr_wr_en,
   input  wire logic [tcl_pkg::IDX_W-1:0] csr_index,
   input  wire logic [tcl_pkg::CFG_W-1:0] csr_wdata
);

   tcl_pkg::cmd_type    cmd;
   tcl_pkg::status_type st;
   logic                in_ready;

   tcl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (in_ready),
      .st       (st),
      .cmd      (cmd)
   );

   tcl_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .in_text_byte    (req.text_byte),
      .in_end_of_text  (req.end_of_text),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .st              (st),
      .out_valid       (rsp.valid),
      .out_ready       (rsp.ready),
      .out_cell_row    (rsp.cell_row),
      .out_cell_column (rsp.cell_column),
      .out_glyph_code  (rsp.glyph_code),
      .out_is_blank    (rsp.is_blank),
      .out_last_of_run (rsp.last_of_run)
   );

   assign req.ready = in_ready;

endmodule

`default_nettype wire

FILE: sv/tcl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tcl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire tcl_pkg::status_type st,
   output tcl_pkg::cmd_type         cmd
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_DECODE  = 2'd1;
   localparam logic [1:0] S_NLFILL  = 2'd2;
   localparam logic [1:0] S_EOTFILL = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.nl_fill) begin
               state_in = S_NLFILL;
            end else if (!st.glyph || st.out_free) begin
               cmd.apply = 1'b1;
               if (st.fill_after_act) begin
                  state_in = S_EOTFILL;
               end else begin
                  cmd.clear = st.eot;
                  state_in  = S_IDLE;
               end
            end
         end
         S_NLFILL: begin
            cmd.nl_mode = 1'b1;
            if (st.out_free) begin
               cmd.blank_step = 1'b1;
               if (st.row_end) begin
                  if (st.fill_after_nl) begin
                     state_in = S_EOTFILL;
                  end else begin
                     cmd.clear = st.eot;
                     state_in  = S_IDLE;
                  end
               end
            end
         end
         S_EOTFILL: begin
            if (st.out_free) begin
               cmd.blank_step = 1'b1;
               if (st.row_end) begin
                  cmd.clear = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/tcl_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module tcl_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [tcl_pkg::BYTE_W-1:0]    in_text_byte,
   input  wire logic                          in_end_of_text,
   input  wire logic                          csr_wr_en,
   input  wire logic [tcl_pkg::IDX_W-1:0]     csr_index,
   input  wire logic [tcl_pkg::CFG_W-1:0]     csr_wdata,
   input  wire tcl_pkg::cmd_type              cmd,
   output tcl_pkg::status_type                st,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [tcl_pkg::POS_W-1:0]          out_cell_row,
   output logic [tcl_pkg::POS_W-1:0]          out_cell_column,
   output logic [tcl_pkg::GLYPH_W-1:0]        out_glyph_code,
   output logic                               out_is_blank,
   output logic                               out_last_of_run
);

   localparam logic [tcl_pkg::CFG_W-1:0] MAX_ROWS_C = tcl_pkg::CFG_W'(tcl_pkg::MAX_ROWS);
   localparam logic [tcl_pkg::CFG_W-1:0] MAX_COLS_C = tcl_pkg::CFG_W'(tcl_pkg::MAX_COLUMNS);
   localparam logic [tcl_pkg::CNT_W-1:0] ONE_C      = tcl_pkg::CNT_W'(1);

   // configuration registers
   logic [tcl_pkg::CFG_W-1:0] row_count_ff;
   logic [tcl_pkg::CFG_W-1:0] column_count_ff;
   logic                      ignore_newline_ff;

   // latched transaction
   logic [tcl_pkg::BYTE_W-1:0] byte_ff;
   logic                       eot_ff;

   // layout state
   logic [tcl_pkg::CNT_W-1:0]  row_ff, row_in;
   logic [tcl_pkg::CNT_W-1:0]  col_ff, col_in;
   logic [tcl_pkg::BYTE_W-1:0] held_ff, held_in;
   logic                       pend_ff, pend_in;
   logic                       stop_ff, stop_in;

   // result register
   logic                         out_valid_ff, out_valid_in;
   logic [tcl_pkg::POS_W-1:0]    out_row_ff, out_row_in;
   logic [tcl_pkg::POS_W-1:0]    out_col_ff, out_col_in;
   logic [tcl_pkg::GLYPH_W-1:0]  out_glyph_ff, out_glyph_in;
   logic                         out_blank_ff, out_blank_in;
   logic                         out_last_ff, out_last_in;

   logic [tcl_pkg::CNT_W-1:0]  rows_eff, cols_eff;
   logic [tcl_pkg::CNT_W-1:0]  row_inc, col_inc, col_sat_inc, lead_row;
   logic [tcl_pkg::CNT_W-1:0]  act_row, act_col;
   logic [tcl_pkg::BYTE_W-1:0] act_held;
   logic                       act_pend, act_stop, act_glyph, act_nl_fill;
   logic                       is_newline, wrap;
   logic                       out_free, emit_glyph, emit;

   always_comb begin
      rows_eff = (row_count_ff == '0) ? ONE_C :
                 (row_count_ff > MAX_ROWS_C) ? MAX_ROWS_C : row_count_ff;
      cols_eff = (column_count_ff == '0) ? ONE_C :
                 (column_count_ff > MAX_COLS_C) ? MAX_COLS_C : column_count_ff;
      row_inc     = (row_ff < tcl_pkg::COUNT_SAT) ? row_ff + ONE_C : row_ff;
      col_sat_inc = (col_ff < tcl_pkg::COUNT_SAT) ? col_ff + ONE_C : col_ff;
      col_inc     = col_ff + ONE_C;
      wrap        = (col_ff >= cols_eff);
      lead_row    = wrap ? row_inc : row_ff;
      is_newline  = !ignore_newline_ff && (byte_ff == tcl_pkg::NEWLINE_BYTE)
                    && (col_ff < cols_eff);
   end

   // effect of one text byte, before any end-of-text padding
   always_comb begin
      act_row     = row_ff;
      act_col     = col_ff;
      act_held    = held_ff;
      act_pend    = pend_ff;
      act_stop    = stop_ff;
      act_glyph   = 1'b0;
      act_nl_fill = 1'b0;
      if (!stop_ff) begin
         if (pend_ff) begin
            act_glyph = 1'b1;
            act_col   = col_sat_inc;
            act_pend  = 1'b0;
         end else if (byte_ff[tcl_pkg::BYTE_W-1]) begin
            act_row = lead_row;
            act_col = wrap ? '0 : col_ff;
            if (lead_row >= rows_eff) begin
               act_stop = 1'b1;
            end else begin
               act_held = byte_ff;
               act_pend = 1'b1;
            end
         end else if (is_newline) begin
            if (row_ff < rows_eff) begin
               act_nl_fill = 1'b1;
            end else begin
               act_row = row_inc;
               act_col = '0;
            end
         end
      end
   end

   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      st                = '0;
      st.out_free       = out_free;
      st.nl_fill        = act_nl_fill;
      st.glyph          = act_glyph;
      st.fill_after_act = eot_ff && !act_stop && (act_row < rows_eff) && (act_col < cols_eff);
      st.row_end        = (col_inc >= cols_eff);
      st.fill_after_nl  = eot_ff && (row_inc < rows_eff);
      st.eot            = eot_ff;
   end

   assign emit_glyph = cmd.apply && act_glyph;
   assign emit       = emit_glyph || cmd.blank_step;

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      held_in = held_ff;
      pend_in = pend_ff;
      stop_in = stop_ff;
      if (cmd.clear) begin
         row_in  = '0;
         col_in  = '0;
         held_in = '0;
         pend_in = 1'b0;
         stop_in = 1'b0;
      end else if (cmd.apply) begin
         row_in  = act_row;
         col_in  = act_col;
         held_in = act_held;
         pend_in = act_pend;
         stop_in = act_stop;
      end else if (cmd.blank_step) begin
         if (st.row_end && cmd.nl_mode) begin
            row_in = row_inc;
            col_in = '0;
         end else begin
            col_in = col_inc;
         end
      end
   end

   always_comb begin
      out_valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_glyph_in = out_glyph_ff;
      out_blank_in = out_blank_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_row_in = row_ff[tcl_pkg::POS_W-1:0];
         out_col_in = col_ff[tcl_pkg::POS_W-1:0];
         if (emit_glyph) begin
            out_glyph_in = {held_ff, byte_ff};
            out_blank_in = 1'b0;
            out_last_in  = !st.fill_after_act;
         end else begin
            out_glyph_in = '0;
            out_blank_in = 1'b1;
            // at end of text a newline run is followed by padding on the next row if that row is on the panel
            out_last_in  = st.row_end && !(cmd.nl_mode && st.fill_after_nl);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff      <= tcl_pkg::RESET_ROW_COUNT;
         column_count_ff   <= tcl_pkg::RESET_COLUMN_COUNT;
         ignore_newline_ff <= 1'b0;
         row_ff            <= '0;
         col_ff            <= '0;
         held_ff           <= '0;
         pend_ff           <= 1'b0;
         stop_ff           <= 1'b0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               tcl_pkg::REG_ROW_COUNT:      row_count_ff      <= csr_wdata;
               tcl_pkg::REG_COLUMN_COUNT:   column_count_ff   <= csr_wdata;
               tcl_pkg::REG_IGNORE_NEWLINE: ignore_newline_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         row_ff       <= row_in;
         col_ff       <= col_in;
         held_ff      <= held_in;
         pend_ff      <= pend_in;
         stop_ff      <= stop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= in_text_byte;
         eot_ff  <= in_end_of_text;
      end
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_glyph_ff <= out_glyph_in;
      out_blank_ff <= out_blank_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid       = out_valid_ff;
   assign out_cell_row    = out_row_ff;
   assign out_cell_column = out_col_ff;
   assign out_glyph_code  = out_glyph_ff;
   assign out_is_blank    = out_blank_ff;
   assign out_last_of_run = out_last_ff;

endmodule

`default_nettype wire

FILE: sv/tcl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tcl_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [tcl_pkg::GLYPH_W-1:0] rsp_glyph_code,
   input wire logic                        rsp_is_blank
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_glyph_code) && $stable(rsp_is_blank))
      else $error("stalled result changed");

   // one transaction at a time: decode follows every accepted byte
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("byte accepted during decode");

   a_blank_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_blank |-> rsp_glyph_code == '0)
      else $error("blank cell with nonzero glyph code");

endmodule

bind text_cell_layout tcl_checker u_tcl_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_glyph_code (rsp.glyph_code),
   .rsp_is_blank   (rsp.is_blank)
);

`default_nettype wire

FILE: tb/sv/tb_text_cell_layout.sv
`timescale 1ns / 1ps

module tb_text_cell_layout;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int SETTLE_CYCLES  = 12;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_ITEMS   = 230;
   localparam int NEWLINE_STORM  = 66;
   localparam int TIMEOUT_NS     = 40_000_000;

   // index past the register list, writes there are dropped
   localparam logic [tcl_pkg::IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct {
      logic [tcl_pkg::POS_W-1:0]   row;
      logic [tcl_pkg::POS_W-1:0]   column;
      logic [tcl_pkg::GLYPH_W-1:0] glyph;
      logic                        blank;
      logic                        last;
   } panel_entry_type;

   class layout_scoreboard;
      logic [tcl_pkg::CFG_W-1:0]  row_count_reg;
      logic [tcl_pkg::CFG_W-1:0]  column_count_reg;
      logic                       ignore_nl;
      logic [tcl_pkg::CNT_W-1:0]  row_pos;
      logic [tcl_pkg::CNT_W-1:0]  col_pos;
      logic [tcl_pkg::BYTE_W-1:0] lead_byte;
      logic                       lead_held;
      logic                       halted;
      panel_entry_type            pending_cells[$];
      panel_entry_type            run_cells[$];
      int unsigned                mismatches;

      function new();
         row_count_reg    = tcl_pkg::RESET_ROW_COUNT;
         column_count_reg = tcl_pkg::RESET_COLUMN_COUNT;
         ignore_nl        = 1'b0;
         mismatches       = 0;
         restart_text();
      endfunction

      function void restart_text();
         row_pos   = '0;
         col_pos   = '0;
         lead_byte = '0;
         lead_held = 1'b0;
         halted    = 1'b0;
      endfunction

      function void write_reg(input logic [tcl_pkg::IDX_W-1:0] idx,
                              input logic [tcl_pkg::CFG_W-1:0] data);
         case (idx)
            tcl_pkg::REG_ROW_COUNT:      row_count_reg = data;
            tcl_pkg::REG_COLUMN_COUNT:   column_count_reg = data;
            tcl_pkg::REG_IGNORE_NEWLINE: ignore_nl = data[0];
            default: ;
         endcase
      endfunction

      function int unsigned clamp_count(input logic [tcl_pkg::CFG_W-1:0] v,
                                        input int unsigned top);
         if (v == 0) return 1;
         if (v > top) return top;
         return v;
      endfunction

      function void add_slot(input logic [tcl_pkg::GLYPH_W-1:0] glyph, input logic blank);
         panel_entry_type e;
         e.row    = row_pos[tcl_pkg::POS_W-1:0];
         e.column = col_pos[tcl_pkg::POS_W-1:0];
         e.glyph  = glyph;
         e.blank  = blank;
         e.last   = 1'b0;
         run_cells.push_back(e);
      endfunction

      // blanks to the end of the row, none below the panel
      function void pad_row(input int unsigned rows, input int unsigned cols);
         if (row_pos >= rows) return;
         while (col_pos < cols) begin
            add_slot('0, 1'b1);
            col_pos++;
         end
      endfunction

      function void place_byte(input logic [tcl_pkg::BYTE_W-1:0] b, input logic eot);
         int unsigned rows;
         int unsigned cols;
         rows = clamp_count(row_count_reg, tcl_pkg::MAX_ROWS);
         cols = clamp_count(column_count_reg, tcl_pkg::MAX_COLUMNS);
         run_cells.delete();
         if (!halted) begin
            if (lead_held) begin
               // any byte after a lead is its trail
               add_slot({lead_byte, b}, 1'b0);
               if (col_pos < tcl_pkg::COUNT_SAT) col_pos++;
               lead_held = 1'b0;
            end else if (b[tcl_pkg::BYTE_W-1]) begin
               if (col_pos >= cols) begin
                  if (row_pos < tcl_pkg::COUNT_SAT) row_pos++;
                  col_pos = '0;
               end
               if (row_pos >= rows) begin
                  halted = 1'b1;
               end else begin
                  lead_byte = b;
                  lead_held = 1'b1;
               end
            end else if (!ignore_nl && b == tcl_pkg::NEWLINE_BYTE && col_pos < cols) begin
               pad_row(rows, cols);
               if (row_pos < tcl_pkg::COUNT_SAT) row_pos++;
               col_pos = '0;
            end
         end
         if (eot) begin
            if (!halted) pad_row(rows, cols);
            restart_text();
         end
         if (run_cells.size() > 0) run_cells[run_cells.size()-1].last = 1'b1;
         foreach (run_cells[i]) pending_cells.push_back(run_cells[i]);
      endfunction

      function int unsigned pending();
         return pending_cells.size();
      endfunction

      function void check_field(input string name, input logic [tcl_pkg::GLYPH_W-1:0] want,
                                input logic [tcl_pkg::GLYPH_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_emitted(input panel_entry_type got);
         panel_entry_type want;
         if (pending_cells.size() == 0) begin
            $error("unexpected result: row %0d column %0d glyph %0h blank %0b",
                   got.row, got.column, got.glyph, got.blank);
            mismatches++;
            return;
         end
         want = pending_cells.pop_front();
         check_field("cell_row", want.row, got.row);
         check_field("cell_column", want.column, got.column);
         check_field("glyph_code", want.glyph, got.glyph);
         check_field("is_blank", want.blank, got.blank);
         check_field("last_of_run", want.last, got.last);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [tcl_pkg::IDX_W-1:0] csr_index;
   logic [tcl_pkg::CFG_W-1:0] csr_wdata;

   tcl_req_if req_ch ();
   tcl_rsp_if rsp_ch ();

   layout_scoreboard sb = new();

   bit          req_offering = 1'b0;
   bit          no_idle = 1'b0;
   bit          hold_request = 1'b0;
   int unsigned effective_items = 0;

   text_cell_layout dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [tcl_pkg::CFG_W-1:0] pick_count(input int unsigned typical_top);
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return tcl_pkg::CFG_W'($urandom_range(1, typical_top));
      if (r < 83) return '0;
      if (r < 91) return tcl_pkg::CFG_W'(32);
      return tcl_pkg::CFG_W'($urandom_range(33, 63));
   endfunction

   task automatic send_byte(input logic [tcl_pkg::BYTE_W-1:0] b, input logic eot);
      int gap;
      gap = no_idle ? 0 : idle_len();
      if (gap > 0) begin
         if (req_offering) req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.text_byte   <= b;
      req_ch.end_of_text <= eot;
      req_offering = 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.place_byte(b, eot);
      effective_items++;
   endtask

   // stop offering, wait for every expected cell and let the block go quiet
   task automatic settle();
      if (req_offering) begin
         req_ch.valid <= 1'b0;
         req_offering = 1'b0;
      end
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_layout(input logic [tcl_pkg::CFG_W-1:0] rows,
                                 input logic [tcl_pkg::CFG_W-1:0] cols,
                                 input bit ign);
      logic [tcl_pkg::IDX_W-1:0] idx_list [4];
      logic [tcl_pkg::CFG_W-1:0] data_list [4];
      idx_list  = '{tcl_pkg::REG_ROW_COUNT, tcl_pkg::REG_COLUMN_COUNT,
                    tcl_pkg::REG_IGNORE_NEWLINE, REG_SPARE};
      data_list[0] = rows;
      data_list[1] = cols;
      // only bit 0 of the newline flag counts
      data_list[2] = tcl_pkg::CFG_W'(($urandom_range(0, 31) << 1) | ign);
      data_list[3] = tcl_pkg::CFG_W'($urandom);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx_list[i];
         csr_wdata <= data_list[i];
         @(posedge clock);
         sb.write_reg(idx_list[i], data_list[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // len counts characters (lead+trail, or a lone final lead), newlines, other bytes
   task automatic send_text(input int unsigned len, input bit terminate);
      int unsigned sent;
      int          r;
      int          t;
      bit          fin;
      logic [tcl_pkg::BYTE_W-1:0] b;
      logic [tcl_pkg::BYTE_W-1:0] trail;
      sent = 0;
      while (sent < len) begin
         r   = $urandom_range(0, 99);
         fin = terminate && (sent + 1 >= len);
         if (r < 55) begin
            b = tcl_pkg::BYTE_W'($urandom_range(128, 255));
            t = $urandom_range(0, 9);
            if (t == 0) trail = tcl_pkg::NEWLINE_BYTE;
            else if (t == 1) trail = '0;
            else trail = tcl_pkg::BYTE_W'($urandom);
            if (fin && $urandom_range(0, 2) == 0) begin
               send_byte(b, 1'b1);
            end else begin
               send_byte(b, 1'b0);
               send_byte(trail, fin);
            end
         end else if (r < 72) begin
            send_byte(tcl_pkg::NEWLINE_BYTE, fin);
         end else if (r < 90) begin
            send_byte(tcl_pkg::BYTE_W'($urandom_range(0, 127)), fin);
         end else begin
            send_byte(tcl_pkg::BYTE_W'($urandom), fin);
         end
         sent++;
      end
   endtask

   task automatic run_phase(input logic [tcl_pkg::CFG_W-1:0] rows,
                            input logic [tcl_pkg::CFG_W-1:0] cols,
                            input bit ign, input int unsigned texts);
      no_idle = ($urandom_range(0, 4) == 0);
      program_layout(rows, cols, ign);
      // the last text may stay open across the next register write
      repeat (texts) send_text($urandom_range(1, 14), $urandom_range(0, 5) != 0);
      settle();
   endtask

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("FAILURE");
      $finish;
   end

   initial begin : result_sink
      int              stall_left;
      int              len;
      logic            ready_next;
      panel_entry_type seen;
      stall_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen.row    = rsp_ch.cell_row;
            seen.column = rsp_ch.cell_column;
            seen.glyph  = rsp_ch.glyph_code;
            seen.blank  = rsp_ch.is_blank;
            seen.last   = rsp_ch.last_of_run;
            sb.check_emitted(seen);
         end
         if (hold_request) begin
            stall_left   = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else begin
            len        = no_idle ? 0 : idle_len();
            ready_next = (len == 0);
            if (len > 0) stall_left = len - 1;
         end
         rsp_ch.ready <= ready_next;
      end
   end

   initial begin : stimulus
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.text_byte   <= '0;
      req_ch.end_of_text <= 1'b0;
      csr_wr_en          <= 1'b0;
      csr_index          <= tcl_pkg::REG_ROW_COUNT;
      csr_wdata          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset layout: 4 rows of 8 cells, newlines honored
      send_byte(8'h80, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(tcl_pkg::NEWLINE_BYTE, 1'b0);   // newline taken as a trail
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(tcl_pkg::NEWLINE_BYTE, 1'b0);
      send_byte(8'hC1, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h81, 1'b1);          // lead dropped by end of text
      send_byte(8'h20, 1'b1);
      send_byte(tcl_pkg::NEWLINE_BYTE, 1'b1);
      settle();

      effective_items = 0;
      // receiver holds off while the sender keeps a transaction waiting
      hold_request = 1'b1;
      run_phase(2, 3, 1'b0, 4);
      run_phase(1, 1, 1'b0, 3);
      run_phase(32, 32, 1'b0, 2);
      run_phase(0, 0, 1'b1, 3);
      run_phase(63, 63, 1'b0, 2);

      // enough newlines to saturate the row counter, then a lead that stops layout
      no_idle = 1'b0;
      program_layout(2, 1, 1'b0);
      repeat (NEWLINE_STORM) send_byte(tcl_pkg::NEWLINE_BYTE, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(tcl_pkg::NEWLINE_BYTE, 1'b1);
      settle();

      while (effective_items < RANDOM_ITEMS)
         run_phase(pick_count(5), pick_count(10), $urandom_range(0, 3) == 0,
                   $urandom_range(2, 5));

      if (sb.mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
